// ----- design/gre_pkg.sv -----
// Package with the types and constants of the gamepad report encoder.
package gre_pkg;

  localparam int unsigned ButtonW = 10;
  localparam int unsigned DirW = 8;
  localparam int unsigned WhammyW = 12;
  localparam int unsigned TimeW = 32;
  localparam int unsigned WordW = 16;
  localparam int unsigned HatW = 3;
  localparam int unsigned ScaledW = 8;
  localparam int unsigned DebounceW = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgReportMode = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounceMs = 1'd1;

  localparam logic [DebounceW-1:0] DebounceReset = 10'd50;

  localparam logic ModeVendor = 1'b0;
  localparam logic ModeHid = 1'b1;

  localparam logic [WordW-1:0] TiltVendor = 16'h8001;
  localparam logic [WordW-1:0] TiltHid = 16'hFF81;

  // Scaling raw*255/4095 equals raw*17/273; the division uses a reciprocal.
  localparam int unsigned ScaleMulW = 17;
  localparam logic [ScaleMulW-1:0] RecipMul = 17'd122911;
  localparam int unsigned RecipShift = 25;
  localparam int unsigned ProductW = 34;

  localparam logic [HatW-1:0] HatUp = 3'd0;
  localparam logic [HatW-1:0] HatUpRight = 3'd1;
  localparam logic [HatW-1:0] HatRight = 3'd2;
  localparam logic [HatW-1:0] HatDownRight = 3'd3;
  localparam logic [HatW-1:0] HatDown = 3'd4;
  localparam logic [HatW-1:0] HatDownLeft = 3'd5;
  localparam logic [HatW-1:0] HatLeft = 3'd6;
  localparam logic [HatW-1:0] HatUpLeft = 3'd7;

  function automatic logic [HatW-1:0] hat_from_lines(input logic [DirW-1:0] dirs);
    logic up;
    logic down;
    logic left;
    logic right;
    logic [HatW-1:0] hat;
    up = |dirs[2:0];
    down = |dirs[5:3];
    left = dirs[6];
    right = dirs[7];
    if (up) begin
      hat = left ? HatUpLeft : (right ? HatUpRight : HatUp);
    end else if (down) begin
      hat = left ? HatDownLeft : (right ? HatDownRight : HatDown);
    end else if (left) begin
      hat = HatLeft;
    end else if (right) begin
      hat = HatRight;
    end else begin
      hat = HatUp;
    end
    return hat;
  endfunction

  function automatic logic [WordW-1:0] vendor_buttons(input logic [ButtonW-1:0] btn,
                                                     input logic [DirW-1:0] dirs);
    logic [WordW-1:0] w;
    w = '0;
    w[12] = btn[0];
    w[13] = btn[1];
    w[15] = btn[2];
    w[14] = btn[3];
    w[5] = btn[4];
    w[0] = btn[5] | (|dirs[2:0]);
    w[1] = btn[6] | (|dirs[5:3]);
    w[4] = btn[7];
    w[3] = btn[8] | dirs[7];
    w[2] = dirs[6];
    w[10] = btn[9];
    return w;
  endfunction

endpackage

// ----- design/gamepad_report_encoder_top.sv -----
// Top level of the gamepad report encoder: tilt debounce and report mapping.

// One poll enters per clock cycle while the input is not stalled. An accepted
// poll is held in an input register and passes through one stage of logic
// into the result register. The tilt debounce state is updated as a poll moves
// from the input register to the result register, so polls are filtered in the
// order they were accepted. The whammy scaling uses one 17 by 17 bit multiply in
// that stage. A new poll is still taken while a finished report waits to be read,
// until the input register is occupied as well; then the input stalls.
module gamepad_report_encoder_top
  import gre_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ButtonW-1:0]         button_bits_i,
  input  logic [DirW-1:0]            direction_lines_i,
  input  logic                       tilt_sample_i,
  input  logic [WhammyW-1:0]         whammy_sample_i,
  input  logic [TimeW-1:0]           now_ms_i,

  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [WordW-1:0]           button_word_o,
  output logic [HatW-1:0]            hat_code_o,
  output logic signed [WordW-1:0]    whammy_axis_o,
  output logic signed [WordW-1:0]    tilt_axis_o
);

  logic                  mode_q;
  logic [DebounceW-1:0]  debounce_q;

  logic                  s1_valid_q, s1_valid_d;
  logic [ButtonW-1:0]    btn_q;
  logic [DirW-1:0]       dirs_q;
  logic                  tilt_in_q;
  logic [WhammyW-1:0]    raw_q;
  logic [TimeW-1:0]      now_q;

  logic                  tilt_q, tilt_d;
  logic [TimeW-1:0]      last_q, last_d;

  logic                  out_valid_q, out_valid_d;
  logic [WordW-1:0]      word_q, word_d;
  logic [HatW-1:0]       hat_q, hat_d;
  logic [WordW-1:0]      whammy_q, whammy_d;
  logic [WordW-1:0]      tilt_axis_q, tilt_axis_d;

  logic                  in_fire;
  logic                  s2_load;
  logic [TimeW-1:0]      elapsed;
  logic [ScaleMulW-1:0]  raw_x17;
  logic [ProductW-1:0]   product;
  logic [ScaledW-1:0]    scaled;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeVendor;
      debounce_q <= DebounceReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgReportMode: mode_q <= cfg_data_i[0];
        CfgDebounceMs: debounce_q <= cfg_data_i[DebounceW-1:0];
        default: ;
      endcase
    end
  end

  assign s2_load = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      btn_q <= button_bits_i;
      dirs_q <= direction_lines_i;
      tilt_in_q <= tilt_sample_i;
      raw_q <= whammy_sample_i;
      now_q <= now_ms_i;
    end
  end

  assign elapsed = now_q - last_q;

  always_comb begin
    tilt_d = tilt_q;
    last_d = last_q;
    if (tilt_in_q != tilt_q) begin
      if (elapsed > {{(TimeW-DebounceW){1'b0}}, debounce_q}) begin
        tilt_d = tilt_in_q;
      end
      last_d = now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q <= 1'b0;
      last_q <= '0;
    end else if (s2_load) begin
      tilt_q <= tilt_d;
      last_q <= last_d;
    end
  end

  assign raw_x17 = {1'b0, raw_q, 4'b0000} + {5'b00000, raw_q};
  assign product = {{(ProductW-ScaleMulW){1'b0}}, raw_x17}
                   * {{(ProductW-ScaleMulW){1'b0}}, RecipMul};
  assign scaled = product[RecipShift+ScaledW-1:RecipShift];

  always_comb begin
    if (mode_q == ModeHid) begin
      word_d = {{(WordW-ButtonW){1'b0}}, btn_q};
      hat_d = hat_from_lines(dirs_q);
      whammy_d = {{(WordW-ScaledW){1'b0}}, scaled};
      tilt_axis_d = tilt_d ? TiltHid : '0;
    end else begin
      word_d = vendor_buttons(btn_q, dirs_q);
      hat_d = HatUp;
      whammy_d = {scaled ^ 8'h80, 8'h00};
      tilt_axis_d = tilt_d ? TiltVendor : '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      word_q <= word_d;
      hat_q <= hat_d;
      whammy_q <= whammy_d;
      tilt_axis_q <= tilt_axis_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign button_word_o = word_q;
  assign hat_code_o = hat_q;
  assign whammy_axis_o = whammy_q;
  assign tilt_axis_o = tilt_axis_q;

  // The debounce state moves only when a poll passes into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_load |=> $stable(tilt_q) && $stable(last_q))
    else $error("Tilt state changed without a poll.");

  // A reported tilt value is one of the three legal codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tilt_axis_o == '0 || tilt_axis_o == TiltVendor
                     || tilt_axis_o == TiltHid))
    else $error("Illegal tilt axis value.");

  // Either the low byte is zero (vendor layout) or the high byte is (HID layout).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (whammy_axis_o[7:0] == 8'h00 || whammy_axis_o[15:8] == 8'h00))
    else $error("Whammy axis mixes layouts.");

  // Input is refused only when both stages are occupied and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("Input stalled without backpressure.");

  // A poll that moves out of the input register is presented at the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_valid_o)
    else $error("Loaded report not presented.");

endmodule

// ----- test/report_checker.sv -----
// Checker for the gamepad report encoder: predicts each report and compares it.
`timescale 1ns / 100ps

module report_checker
  import gre_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,

  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [ButtonW-1:0]       button_bits_i,
  input  logic [DirW-1:0]          direction_lines_i,
  input  logic                     tilt_sample_i,
  input  logic [WhammyW-1:0]       whammy_sample_i,
  input  logic [TimeW-1:0]         now_ms_i,

  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [WordW-1:0]         button_word_i,
  input  logic [HatW-1:0]          hat_code_i,
  input  logic signed [WordW-1:0]  whammy_axis_i,
  input  logic signed [WordW-1:0]  tilt_axis_i,

  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [WordW-1:0]        buttons;
    logic [HatW-1:0]         hat;
    logic signed [WordW-1:0] whammy;
    logic signed [WordW-1:0] tilt;
  } report_t;

  report_t report_queue[$];
  report_t want;
  logic mode;
  logic [DebounceW-1:0] lockout;
  logic held;
  logic [TimeW-1:0] last_flip_ms;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic report_t build_report(input logic rep_mode, input logic [ButtonW-1:0] btn,
                                           input logic [DirW-1:0] dirs,
                                           input logic [WhammyW-1:0] raw, input logic tilted);
    logic up;
    logic down;
    logic left;
    logic right;
    int unsigned scaled;
    report_t r;
    up = |dirs[2:0];
    down = |dirs[5:3];
    left = dirs[6];
    right = dirs[7];
    scaled = (32'(raw) * 32'd255) / 32'd4095;
    r = '0;
    if (rep_mode == ModeVendor) begin
      r.buttons = {btn[2], btn[3], btn[1], btn[0], 1'b0, btn[9], 4'b0000, btn[4], btn[7],
                   btn[8] | right, left, btn[6] | down, btn[5] | up};
      r.whammy = WordW'(int'(scaled) * 256 - 32768);
      r.tilt = tilted ? -16'sd32767 : 16'sd0;
    end else begin
      r.buttons = WordW'(btn);
      casez ({up, down, left, right})
        4'b1?1?: r.hat = HatUpLeft;
        4'b1?01: r.hat = HatUpRight;
        4'b1?00: r.hat = HatUp;
        4'b011?: r.hat = HatDownLeft;
        4'b0101: r.hat = HatDownRight;
        4'b0100: r.hat = HatDown;
        4'b001?: r.hat = HatLeft;
        4'b0001: r.hat = HatRight;
        default: r.hat = HatUp;
      endcase
      r.whammy = WordW'(scaled);
      r.tilt = tilted ? -16'sd127 : 16'sd0;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode = ModeVendor;
      lockout = DebounceReset;
      held = 1'b0;
      last_flip_ms = '0;
      report_queue.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgReportMode: mode = cfg_data_i[0];
          CfgDebounceMs: lockout = cfg_data_i[DebounceW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (report_queue.size() == 0) begin
          $error("Report transaction arrived with no poll outstanding.");
          fail_count_o++;
        end else begin
          want = report_queue.pop_front();
          check_field("button_word", int'(want.buttons), int'(button_word_i));
          check_field("hat_code", int'(want.hat), int'(hat_code_i));
          check_field("whammy_axis", int'($signed(want.whammy)), int'($signed(whammy_axis_i)));
          check_field("tilt_axis", int'($signed(want.tilt)), int'($signed(tilt_axis_i)));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (tilt_sample_i != held) begin
          if ((now_ms_i - last_flip_ms) > TimeW'(lockout)) begin
            held = tilt_sample_i;
          end
          last_flip_ms = now_ms_i;
        end
        report_queue.push_back(build_report(mode, button_bits_i, direction_lines_i,
                                            whammy_sample_i, held));
      end
      pending_o = report_queue.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the gamepad report encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import gre_pkg::*;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [ButtonW-1:0]       button_bits_i;
  logic [DirW-1:0]          direction_lines_i;
  logic                     tilt_sample_i;
  logic [WhammyW-1:0]       whammy_sample_i;
  logic [TimeW-1:0]         now_ms_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [WordW-1:0]         button_word_o;
  logic [HatW-1:0]          hat_code_o;
  logic signed [WordW-1:0]  whammy_axis_o;
  logic signed [WordW-1:0]  tilt_axis_o;

  int fail_count;
  int pending;
  bit steady;
  bit choke;
  logic [TimeW-1:0] clock_ms;
  logic tilt_level;
  int unsigned lockout_now;

  gamepad_report_encoder_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .button_bits_i     (button_bits_i),
    .direction_lines_i (direction_lines_i),
    .tilt_sample_i     (tilt_sample_i),
    .whammy_sample_i   (whammy_sample_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .button_word_o     (button_word_o),
    .hat_code_o        (hat_code_o),
    .whammy_axis_o     (whammy_axis_o),
    .tilt_axis_o       (tilt_axis_o)
  );

  report_checker report_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .button_bits_i     (button_bits_i),
    .direction_lines_i (direction_lines_i),
    .tilt_sample_i     (tilt_sample_i),
    .whammy_sample_i   (whammy_sample_i),
    .now_ms_i          (now_ms_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .button_word_i     (button_word_o),
    .hat_code_i        (hat_code_o),
    .whammy_axis_i     (whammy_axis_o),
    .tilt_axis_i       (tilt_axis_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_poll(input logic [ButtonW-1:0] btn, input logic [DirW-1:0] dirs,
                           input logic tilt, input logic [WhammyW-1:0] raw,
                           input logic [TimeW-1:0] stamp);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    button_bits_i = btn;
    direction_lines_i = dirs;
    tilt_sample_i = tilt;
    whammy_sample_i = raw;
    now_ms_i = stamp;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_reports(input int settle);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic configure(input logic rep_mode, input logic [DebounceW-1:0] deb);
    drain_reports(4);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CfgReportMode, CfgDataW'(rep_mode));
      write_reg(CfgDebounceMs, CfgDataW'(deb));
    end else begin
      write_reg(CfgDebounceMs, CfgDataW'(deb));
      write_reg(CfgReportMode, CfgDataW'(rep_mode));
    end
    cfg_valid_i = 1'b0;
    lockout_now = 32'(deb);
  endtask

  task automatic random_poll();
    logic [ButtonW-1:0] btn;
    logic [DirW-1:0] dirs;
    logic [WhammyW-1:0] raw;
    case ($urandom_range(0, 7))
      0: btn = '0;
      1: btn = '1;
      default: btn = ButtonW'($urandom);
    endcase
    dirs = DirW'($urandom);
    case ($urandom_range(0, 5))
      0: raw = '0;
      1: raw = '1;
      default: raw = WhammyW'($urandom);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      tilt_level = ~tilt_level;
    end
    case ($urandom_range(0, 9))
      0: ;
      1: clock_ms = clock_ms + lockout_now;
      2: clock_ms = clock_ms + lockout_now + 1;
      3: clock_ms = clock_ms + lockout_now - ((lockout_now > 0) ? 1 : 0);
      4: clock_ms = $urandom;
      5: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: clock_ms = clock_ms + $urandom_range(1, 2 * lockout_now + 2);
    endcase
    send_poll(btn, dirs, tilt_level, raw, clock_ms);
  endtask

  task automatic run_phase(input logic rep_mode, input logic [DebounceW-1:0] deb,
                           input int count, input bit no_idle, input bit squeeze);
    configure(rep_mode, deb);
    steady = no_idle;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == 30) begin
        choke = 1'b1;
      end
      random_poll();
    end
    steady = 1'b0;
  endtask

  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (choke) begin
        out_ready_i = 1'b0;
        repeat (60) @(negedge clk_i);
        choke = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    button_bits_i = '0;
    direction_lines_i = '0;
    tilt_sample_i = 1'b0;
    whammy_sample_i = '0;
    now_ms_i = '0;
    steady = 1'b0;
    choke = 1'b0;
    lockout_now = 32'(DebounceReset);
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: vendor layout, 50 ms lockout, including a wrap of the time.
    send_poll('0, '0, 1'b0, '0, 32'd0);
    send_poll('1, '1, 1'b0, '1, 32'd1);
    send_poll(10'h001, 8'h01, 1'b1, 12'd2048, 32'd50);
    send_poll(10'h002, 8'h08, 1'b1, 12'd1, 32'd101);
    send_poll(10'h004, 8'h40, 1'b0, 12'd4094, 32'hFFFF_FFF0);
    send_poll(10'h008, 8'h80, 1'b1, 12'd16, 32'h0000_0010);
    send_poll(10'h010, 8'h00, 1'b1, 12'd17, 32'h0000_0043);

    // Zero lockout rejects a change only at the same millisecond.
    configure(ModeHid, 10'd0);
    send_poll(10'h020, 8'h01, 1'b0, 12'd4095, 32'h50);
    send_poll(10'h040, 8'h81, 1'b1, 12'd0, 32'h60);
    send_poll(10'h080, 8'h88, 1'b0, 12'd273, 32'h60);
    send_poll(10'h100, 8'h48, 1'b0, 12'd272, 32'h61);

    send_poll(10'h200, 8'h02, 1'b0, 12'd100, 32'h70);
    send_poll(10'h155, 8'hC1, 1'b0, 12'd200, 32'h71);
    send_poll(10'h2AA, 8'h10, 1'b0, 12'd300, 32'h72);
    send_poll(10'h3FF, 8'hC8, 1'b0, 12'd400, 32'h73);
    send_poll(10'h000, 8'h40, 1'b0, 12'd500, 32'h74);
    send_poll(10'h001, 8'h80, 1'b0, 12'd600, 32'h75);
    send_poll(10'h002, 8'hC0, 1'b0, 12'd700, 32'h76);
    send_poll(10'h004, 8'h09, 1'b0, 12'd800, 32'h77);
    send_poll(10'h008, 8'h00, 1'b0, 12'd900, 32'h78);

    // Lockout above the nominal range is used as written.
    configure(ModeVendor, 10'd1023);
    send_poll(10'h010, 8'h24, 1'b1, 12'd3000, 32'h61 + 32'd1023);
    send_poll(10'h020, 8'h12, 1'b1, 12'd3500, 32'h61 + 32'd2047);
    clock_ms = 32'h61 + 32'd2047;
    tilt_level = 1'b1;

    run_phase(ModeHid, 10'd1000, 144, 1'b0, 1'b0);
    run_phase(ModeVendor, 10'd0, 144, 1'b1, 1'b1);
    run_phase(ModeHid, 10'd1023, 144, 1'b0, 1'b0);
    run_phase(ModeVendor, 10'd1, 144, 1'b0, 1'b0);
    run_phase(ModeHid, DebounceW'($urandom_range(0, 1023)), 144, 1'b1, 1'b0);
    run_phase(ModeVendor, 10'd1000, 144, 1'b0, 1'b0);
    run_phase(ModeHid, 10'd0, 144, 1'b0, 1'b0);
    run_phase(ModeVendor, DebounceW'($urandom_range(0, 1023)), 144, 1'b0, 1'b0);

    drain_reports(10);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
